[hdl/ufk_pkg.sv]
// Types, constants and decode helpers shared by the UTF-8 folding tokenizer.
// No dependencies; compiled first.
package ufk_pkg;

  // Input item: one text byte and its end-of-text flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_item_t;

  // Result item as seen on the output channel
  typedef struct packed {
    logic [6:0] out_char;
    logic       token_end;
    logic       last_of_run;
  } out_item_t;

  // One queued result before its last-of-run flag is known
  typedef struct packed {
    logic [6:0] out_char;
    logic       token_end;
  } res_t;

  // Candidate character with a valid flag
  typedef struct packed {
    logic       valid;
    logic [6:0] ch;
  } char_t;

  // All results caused by one item, in order, entry 0 first
  typedef struct packed {
    logic [1:0]     count;
    res_t [2:0]     entry;
  } batch_t;

  // Pending multibyte sequence length codes
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Lead byte patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  // Latin-1 folding window and case mask
  localparam logic [10:0] LATIN_LOW  = 11'h0C0;
  localparam logic [10:0] LATIN_HIGH = 11'h0FF;
  localparam logic [7:0]  CASE_MASK  = 8'hDF;

  // Folded base letters
  localparam logic [6:0] CH_A = 7'h61;
  localparam logic [6:0] CH_E = 7'h65;
  localparam logic [6:0] CH_I = 7'h69;
  localparam logic [6:0] CH_N = 7'h6E;
  localparam logic [6:0] CH_O = 7'h6F;
  localparam logic [6:0] CH_U = 7'h75;

  // Piece separators: space, tab, LF, CR, period, comma, hyphen, underscore
  function automatic logic is_delim(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
           (b == 8'h2E) || (b == 8'h2C) || (b == 8'h2D) || (b == 8'h5F);
  endfunction

  // Lowercase letters, keep digits, drop everything else
  function automatic char_t ascii_canon(logic [7:0] b);
    char_t r;
    r.valid = 1'b0;
    r.ch    = b[6:0];
    if ((b >= 8'h41) && (b <= 8'h5A)) begin
      r.valid = 1'b1;
      r.ch    = b[6:0] | 7'h20;
    end else if (((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h30) && (b <= 8'h39))) begin
      r.valid = 1'b1;
    end
    return r;
  endfunction

  // Sequence length announced by a lead byte, none for anything else
  function automatic logic [2:0] lead_len(logic [7:0] b);
    if ((b & LEAD2_MASK) == LEAD2_CODE) return SEQ_LEN2;
    if ((b & LEAD3_MASK) == LEAD3_CODE) return SEQ_LEN3;
    if ((b & LEAD4_MASK) == LEAD4_CODE) return SEQ_LEN4;
    return SEQ_NONE;
  endfunction

  // Fold a two-byte sequence onto its base letter, if it has one
  function automatic char_t fold2(logic [7:0] lead, logic [7:0] cont);
    logic [10:0] cp;
    logic [7:0]  u;
    char_t       r;
    cp      = {lead[4:0], cont[5:0]};
    u       = cp[7:0] & CASE_MASK;
    r.valid = 1'b0;
    r.ch    = CH_A;
    if ((cp >= LATIN_LOW) && (cp <= LATIN_HIGH)) begin
      if (u <= 8'hC5) begin
        r.valid = 1'b1;
        r.ch    = CH_A;
      end else if ((u >= 8'hC8) && (u <= 8'hCB)) begin
        r.valid = 1'b1;
        r.ch    = CH_E;
      end else if ((u >= 8'hCC) && (u <= 8'hCF)) begin
        r.valid = 1'b1;
        r.ch    = CH_I;
      end else if (u == 8'hD1) begin
        r.valid = 1'b1;
        r.ch    = CH_N;
      end else if ((u >= 8'hD2) && (u <= 8'hD6)) begin
        r.valid = 1'b1;
        r.ch    = CH_O;
      end else if ((u >= 8'hD9) && (u <= 8'hDC)) begin
        r.valid = 1'b1;
        r.ch    = CH_U;
      end
    end
    return r;
  endfunction

endpackage

[hdl/ufk_stream_if.sv]
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is set per instance from ufk_pkg.
interface ufk_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/utf8_fold_tokenizer_core.sv]
// UTF-8 folding tokenizer top level: input register, decode, result queue.
// The input register holds a byte; its decoded results load into the result queue.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is ready; a byte giving more results holds the queue until they have left.
// Reset (async, active low) clears sequence, token and valid state; no clearing pass.
// Depends on ufk_pkg, ufk_stream_if, ufk_decode and ufk_serial.
module utf8_fold_tokenizer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  ufk_stream_if.sink   in_i,
  ufk_stream_if.source out_o
);
  import ufk_pkg::*;

  logic     s0_valid_q;
  in_item_t s0_item_q;
  batch_t   batch;
  logic     can_load, advance, load;

  // Move the held byte on once its results have a place in the queue
  assign advance    = s0_valid_q & ((batch.count == 2'd0) | can_load);
  assign load       = s0_valid_q & (batch.count != 2'd0) & can_load;
  assign in_i.ready = ~s0_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_item_q <= in_i.data;
    end
  end

  ufk_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (s0_item_q),
    .advance_i (advance),
    .batch_o   (batch)
  );

  ufk_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .batch_i    (batch),
    .load_i     (load),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

[hdl/ufk_decode.sv]
// Per-byte decode: sequence tracking, folding, piece ending and result list.
// Uses ufk_pkg; state advances when the top level moves the held item on.
module ufk_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufk_pkg::in_item_t item_i,
  input  logic              advance_i,
  output ufk_pkg::batch_t   batch_o
);
  import ufk_pkg::*;

  logic [7:0] held_q [3];
  logic [7:0] held_d [3];
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [2:0] seq_len_q, seq_len_d;
  logic       tok_q, tok_d;

  logic       delim, finish, h1_lead2, tok_after, end_v;
  logic [7:0] b, h0, h1, h2;
  logic [2:0] cnt_plus1, seq_f;
  logic [1:0] cnt_f, nch;
  char_t      feed_c, tail_a, tail_b, fold_t, asc_h1, asc_h2, first_c, second_c;

  // Feed the byte into the pending sequence, or decode it alone
  always_comb begin
    b         = item_i.in_byte;
    delim     = is_delim(b);
    finish    = delim | item_i.text_end;
    cnt_plus1 = {1'b0, held_cnt_q} + 3'd1;
    h0        = held_q[0];
    h1        = held_q[1];
    h2        = held_q[2];
    cnt_f     = held_cnt_q;
    seq_f     = seq_len_q;
    feed_c    = '0;
    if (!delim) begin
      if (seq_len_q == SEQ_NONE) begin
        feed_c = ascii_canon(b);
        seq_f  = lead_len(b);
        if (seq_f != SEQ_NONE) begin
          h0    = b;
          cnt_f = 2'd1;
        end
      end else if (cnt_plus1 >= seq_len_q) begin
        if (seq_len_q == SEQ_LEN2) begin
          feed_c = fold2(held_q[0], b);
        end
        seq_f = SEQ_NONE;
        cnt_f = 2'd0;
      end else begin
        if (held_cnt_q == 2'd1) begin
          h1 = b;
        end else begin
          h2 = b;
        end
        cnt_f = cnt_plus1[1:0];
      end
    end
  end

  // Reprocess the bytes held after a truncated lead byte
  always_comb begin
    asc_h1   = ascii_canon(h1);
    asc_h2   = ascii_canon(h2);
    fold_t   = fold2(h1, h2);
    h1_lead2 = (lead_len(h1) == SEQ_LEN2);
    tail_a   = '0;
    tail_b   = '0;
    if (finish && (seq_f != SEQ_NONE)) begin
      if (cnt_f == 2'd2) begin
        tail_a = asc_h1;
      end else if (cnt_f == 2'd3) begin
        if (h1_lead2) begin
          tail_a = fold_t;
        end else begin
          tail_a = asc_h1;
          tail_b = asc_h2;
        end
      end
    end
  end

  // Pack characters first, then the token end; a fed character and a tail exclude each other
  always_comb begin
    if (feed_c.valid) begin
      first_c = feed_c;
    end else if (tail_a.valid) begin
      first_c = tail_a;
    end else begin
      first_c = tail_b;
    end
    second_c       = '0;
    second_c.ch    = tail_b.ch;
    second_c.valid = tail_a.valid & tail_b.valid;
    nch            = {1'b0, first_c.valid} + {1'b0, second_c.valid};
    tok_after      = tok_q | first_c.valid;
    end_v          = finish & tok_after;

    batch_o.count = nch + {1'b0, end_v};
    batch_o.entry[0] = first_c.valid ? res_t'{out_char: first_c.ch, token_end: 1'b0}
                                     : res_t'{out_char: 7'd0, token_end: 1'b1};
    batch_o.entry[1] = second_c.valid ? res_t'{out_char: second_c.ch, token_end: 1'b0}
                                      : res_t'{out_char: 7'd0, token_end: 1'b1};
    batch_o.entry[2] = res_t'{out_char: 7'd0, token_end: 1'b1};
  end

  // Next state: a finished piece clears the sequence and the token flag
  always_comb begin
    held_d[0]  = h0;
    held_d[1]  = h1;
    held_d[2]  = h2;
    seq_len_d  = finish ? SEQ_NONE : seq_f;
    held_cnt_d = finish ? 2'd0 : cnt_f;
    tok_d      = finish ? 1'b0 : tok_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      seq_len_q  <= SEQ_NONE;
      tok_q      <= 1'b0;
    end else if (advance_i) begin
      held_cnt_q <= held_cnt_d;
      seq_len_q  <= seq_len_d;
      tok_q      <= tok_d;
    end
  end

  // Held bytes carry no reset; only entries below the count are read
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      held_q <= held_d;
    end
  end

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q == SEQ_NONE) |-> (held_cnt_q == 2'd0))
    else $error("held bytes present with no sequence pending");

  a_count_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q != SEQ_NONE) |-> (({1'b0, held_cnt_q} < seq_len_q) && (held_cnt_q != 2'd0)))
    else $error("held count out of range for pending sequence");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && finish) |=> (!tok_q && (seq_len_q == SEQ_NONE)))
    else $error("piece end did not clear token state");

endmodule

[hdl/ufk_serial.sv]
// Result queue: holds the results of one item and sends them one per cycle
// while ready. Uses ufk_pkg, ufk_stream_if; loads when empty or last leaves.
module ufk_serial (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ufk_pkg::batch_t      batch_i,
  input  logic                 load_i,
  output logic                 can_load_o,
  ufk_stream_if.source         out_o
);
  import ufk_pkg::*;

  res_t       ent_q [3];
  logic [1:0] cnt_q;
  logic       fire;

  // Drive the head result
  assign fire                  = out_o.valid & out_o.ready;
  assign can_load_o            = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_o.ready);
  assign out_o.valid           = (cnt_q != 2'd0);
  assign out_o.data.out_char   = ent_q[0].out_char;
  assign out_o.data.token_end  = ent_q[0].token_end;
  assign out_o.data.last_of_run = (cnt_q == 2'd1);

  // Count: reload or drop one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
    end else if (fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Entries: reload or shift toward the head
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q[0] <= batch_i.entry[0];
      ent_q[1] <= batch_i.entry[1];
      ent_q[2] <= batch_i.entry[2];
    end else if (fire) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (can_load_o && (batch_i.count != 2'd0)))
    else $error("result list loaded over pending results");

  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (cnt_q == 2'd1) && !load_i) |=> !out_o.valid)
    else $error("results remain after last of run left");

  a_end_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.token_end) |-> (out_o.data.out_char == 7'd0))
    else $error("token end carries a character");

endmodule
